// File: src/i2cm_pkg.sv
// Shared types for the I2C master bit engine: request codes, sequencer
// phases, and the command and result records passed between front and back.
// No dependencies.
package i2cm_pkg;

  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_START = 3'd1,
    REQ_STOP  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_READ  = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ST_W1  = 4'd1,
    PH_ST_W2  = 4'd2,
    PH_SP_W1  = 4'd3,
    PH_SP_STR = 4'd4,
    PH_SP_W2  = 4'd5,
    PH_WR_LO  = 4'd6,
    PH_WR_HI  = 4'd7,
    PH_WR_ALO = 4'd8,
    PH_WR_AHI = 4'd9,
    PH_WR_END = 4'd10,
    PH_RD_LO  = 4'd11,
    PH_RD_HI  = 4'd12,
    PH_AK_LO  = 4'd13,
    PH_AK_HI  = 4'd14,
    PH_AK_END = 4'd15
  } phase_e;

  typedef struct packed {
    req_e       req;
    logic [7:0] data;
    logic       ack;
    logic       sda;
    logic       scl;
  } cmd_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       ready;
    logic       done;
    logic       ack_seen;
    logic [7:0] read_byte;
    logic       bus_busy;
  } res_t;

endpackage

// File: src/i2c_master_bit_engine_core.sv
// Top level of the I2C master bit engine: APB delay register, front end and
// sequencer back end. Uses i2cm_pkg, i2cm_front and i2cm_back.
//
//   channel   handshake            payload
//   ticks     push_i / full_o      req_type_i data_byte_i send_ack_i sda_in_i scl_in_i
//   results   pop_i / empty_o      scl/sda drives, ready, done, ack_seen, read_byte,
//                                  bus_busy
//   config    psel/penable/pwrite  paddr, pwdata, prdata (delay_ticks at 0x0)
//
// One tick request per cycle sustained while the result queue has room; a taken
// request is registered in the command queue, and the sequencer step on it
// registers its result in the result queue.
// full_o rises only when the result queue is full and the command queue backs up.
// Reset clears the queues, the sequencer and sets delay_ticks to 2; no sweep.
module i2c_master_bit_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        send_ack_i,
  input  logic        sda_in_i,
  input  logic        scl_in_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic        scl_drive_low_o,
  output logic        sda_drive_low_o,
  output logic        ready_res_o,
  output logic        done_res_o,
  output logic        ack_seen_o,
  output logic [7:0]  read_byte_o,
  output logic        bus_busy_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cm_pkg::*;

  localparam logic [15:0] DelayRst = 16'd2;

  logic [15:0] delay_q, delay_d;
  logic        cmd_valid, cmd_pop;
  cmd_t        cmd;
  res_t        res;
  logic        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);
  assign prdata  = reg_hit ? {16'd0, delay_q} : 32'd0;

  always_comb begin
    delay_d = delay_q;
    if (psel && penable && pwrite && reg_hit) begin
      delay_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayRst;
    end else begin
      delay_q <= delay_d;
    end
  end

  i2cm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .send_ack_i  (send_ack_i),
    .sda_in_i    (sda_in_i),
    .scl_in_i    (scl_in_i),
    .full_o      (full_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  i2cm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .delay_ticks_i (delay_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .res_empty_o   (empty_o),
    .res_pop_i     (pop_i),
    .res_o         (res)
  );

  assign scl_drive_low_o = res.scl_low;
  assign sda_drive_low_o = res.sda_low;
  assign ready_res_o     = res.ready;
  assign done_res_o      = res.done;
  assign ack_seen_o      = res.ack_seen;
  assign read_byte_o     = res.read_byte;
  assign bus_busy_o      = res.bus_busy;

endmodule

// File: src/i2cm_front.sv
// Front end: takes tick requests, classifies the request type and holds
// them in a two-entry command queue for the sequencer. Uses i2cm_pkg.
module i2cm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [2:0]     req_type_i,
  input  logic [7:0]     data_byte_i,
  input  logic           send_ack_i,
  input  logic           sda_in_i,
  input  logic           scl_in_i,
  output logic           full_o,
  output logic           cmd_valid_o,
  output i2cm_pkg::cmd_t cmd_o,
  input  logic           cmd_pop_i
);
  import i2cm_pkg::*;

  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  cmd_t            q_mem [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  cmd_t            cmd_in;
  req_e            req_c;
  logic            do_push, do_pop;

  // Fold unused codes into a plain tick.
  always_comb begin
    case (req_type_i)
      REQ_START: req_c = REQ_START;
      REQ_STOP:  req_c = REQ_STOP;
      REQ_WRITE: req_c = REQ_WRITE;
      REQ_READ:  req_c = REQ_READ;
      default:   req_c = REQ_TICK;
    endcase
  end

  assign cmd_in.req  = req_c;
  assign cmd_in.data = data_byte_i;
  assign cmd_in.ack  = send_ack_i;
  assign cmd_in.sda  = sda_in_i;
  assign cmd_in.scl  = scl_in_i;

  assign full_o      = (cnt_q == CntW'(QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// File: src/i2cm_back.sv
// Back end: the bus sequencer, one tick per cycle while the result queue has room, and a two-entry result
// queue. Uses i2cm_pkg; fed by i2cm_front.
module i2cm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    delay_ticks_i,
  input  logic           cmd_valid_i,
  input  i2cm_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           res_empty_o,
  input  logic           res_pop_i,
  output i2cm_pkg::res_t res_o
);
  import i2cm_pkg::*;

  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] dly_q, dly_d;
  logic        ack_choice_q, ack_choice_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        ack_seen_q, ack_seen_d;
  logic        bus_busy_q, bus_busy_d;
  logic [7:0]  last_read_q, last_read_d;
  logic        go, dec, ready_c, done_c;
  logic        fire, wait_c;
  logic [3:0]  cnt_inc;

  res_t            r_mem [QDepth];
  res_t            res_in;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            res_full, do_pop;

  assign res_full  = (cnt_q == CntW'(QDepth));
  assign fire      = cmd_valid_i && !res_full;
  assign cmd_pop_o = fire;
  assign wait_c    = (phase_q != PH_SP_STR) && (dly_q > 16'd1);
  assign cnt_inc   = bit_cnt_q + 4'd1;

  // Next phase and delay reload.
  always_comb begin
    phase_d = phase_q;
    go      = 1'b0;
    dec     = 1'b0;
    if (fire) begin
      if (phase_q == PH_IDLE) begin
        case (cmd_i.req)
          REQ_START: begin phase_d = PH_ST_W1; go = 1'b1; end
          REQ_STOP:  begin phase_d = PH_SP_W1; go = 1'b1; end
          REQ_WRITE: begin phase_d = PH_WR_LO; go = 1'b1; end
          REQ_READ:  begin phase_d = PH_RD_LO; go = 1'b1; end
          default:   phase_d = PH_IDLE;
        endcase
      end else if (phase_q == PH_SP_STR) begin
        if (cmd_i.scl) begin
          phase_d = PH_SP_W2;
          go      = 1'b1;
        end
      end else if (wait_c) begin
        dec = 1'b1;
      end else begin
        case (phase_q)
          PH_ST_W1: begin
            if (!cmd_i.sda) begin
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_ST_W2;
              go      = 1'b1;
            end
          end
          PH_SP_W1: begin
            if (cmd_i.scl) begin
              phase_d = PH_SP_W2;
              go      = 1'b1;
            end else begin
              phase_d = PH_SP_STR;
            end
          end
          PH_WR_LO:  begin phase_d = PH_WR_HI; go = 1'b1; end
          PH_WR_HI:  begin phase_d = cnt_inc[3] ? PH_WR_ALO : PH_WR_LO; go = 1'b1; end
          PH_WR_ALO: begin phase_d = PH_WR_AHI; go = 1'b1; end
          PH_WR_AHI: begin phase_d = PH_WR_END; go = 1'b1; end
          PH_RD_LO:  begin phase_d = PH_RD_HI; go = 1'b1; end
          PH_RD_HI:  begin phase_d = cnt_inc[3] ? PH_AK_LO : PH_RD_LO; go = 1'b1; end
          PH_AK_LO:  begin phase_d = PH_AK_HI; go = 1'b1; end
          PH_AK_HI:  begin phase_d = PH_AK_END; go = 1'b1; end
          default:   phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    if (go) begin
      dly_d = delay_ticks_i;
    end else if (dec) begin
      dly_d = dly_q - 16'd1;
    end else begin
      dly_d = dly_q;
    end
  end

  // Line drives, shifter and status.
  always_comb begin
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    ack_seen_d   = ack_seen_q;
    bus_busy_d   = bus_busy_q;
    last_read_d  = last_read_q;
    ready_c      = 1'b0;
    done_c       = 1'b0;
    if (fire) begin
      if (phase_q == PH_IDLE) begin
        ready_c = 1'b1;
        case (cmd_i.req)
          REQ_START: begin
            bus_busy_d = 1'b0;
            scl_d      = 1'b0;
            sda_d      = 1'b0;
          end
          REQ_STOP: begin
            sda_d = 1'b1;
            scl_d = 1'b0;
          end
          REQ_WRITE: begin
            ack_seen_d = 1'b0;
            shift_d    = cmd_i.data;
            bit_cnt_d  = '0;
            sda_d      = ~cmd_i.data[7];
          end
          REQ_READ: begin
            ack_choice_d = cmd_i.ack;
            shift_d      = '0;
            bit_cnt_d    = '0;
            sda_d        = 1'b0;
            scl_d        = 1'b1;
          end
          default: ;
        endcase
      end else if (phase_q == PH_SP_STR) begin
        if (cmd_i.scl) begin
          sda_d = 1'b0;
        end
      end else if (!wait_c) begin
        case (phase_q)
          PH_ST_W1: begin
            if (!cmd_i.sda) begin
              bus_busy_d = 1'b1;
              done_c     = 1'b1;
            end else begin
              sda_d = 1'b1;
            end
          end
          PH_ST_W2: begin
            scl_d  = 1'b1;
            done_c = 1'b1;
          end
          PH_SP_W1: begin
            if (cmd_i.scl) begin
              sda_d = 1'b0;
            end
          end
          PH_SP_W2:  done_c = 1'b1;
          PH_WR_LO:  scl_d = 1'b0;
          PH_WR_HI: begin
            shift_d   = {shift_q[6:0], 1'b0};
            scl_d     = 1'b1;
            bit_cnt_d = cnt_inc;
            sda_d     = cnt_inc[3] ? 1'b0 : ~shift_q[6];
          end
          PH_WR_ALO: scl_d = 1'b0;
          PH_WR_AHI: begin
            if (!cmd_i.sda) begin
              ack_seen_d = 1'b1;
            end
            scl_d = 1'b1;
          end
          PH_WR_END: done_c = 1'b1;
          PH_RD_LO:  scl_d = 1'b0;
          PH_RD_HI: begin
            shift_d   = {shift_q[6:0], cmd_i.sda};
            bit_cnt_d = cnt_inc;
            scl_d     = 1'b1;
            if (cnt_inc[3]) begin
              sda_d = ack_choice_q;
            end
          end
          PH_AK_LO:  scl_d = 1'b0;
          PH_AK_HI:  scl_d = 1'b1;
          PH_AK_END: begin
            sda_d       = 1'b0;
            last_read_d = shift_q;
            done_c      = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_cnt_q    <= '0;
      shift_q      <= '0;
      dly_q        <= '0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b0;
      sda_q        <= 1'b0;
      ack_seen_q   <= 1'b0;
      bus_busy_q   <= 1'b0;
      last_read_q  <= '0;
    end else begin
      phase_q      <= phase_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_q      <= shift_d;
      dly_q        <= dly_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      ack_seen_q   <= ack_seen_d;
      bus_busy_q   <= bus_busy_d;
      last_read_q  <= last_read_d;
    end
  end

  // Result queue.
  assign res_in.scl_low   = scl_d;
  assign res_in.sda_low   = sda_d;
  assign res_in.ready     = ready_c;
  assign res_in.done      = done_c;
  assign res_in.ack_seen  = ack_seen_d;
  assign res_in.read_byte = last_read_d;
  assign res_in.bus_busy  = bus_busy_d;

  assign res_empty_o = (cnt_q == '0);
  assign res_o       = r_mem[rd_ptr_q];
  assign do_pop      = res_pop_i && !res_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (fire) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({fire, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      r_mem[wr_ptr_q] <= res_in;
    end
  end

endmodule

// File: src/i2cm_checker.sv
// Port-level checks for the I2C master bit engine, bound to the top level.
// Depends only on the ports of i2c_master_bit_engine_core.
module i2cm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full_o,
  input logic       empty_o,
  input logic       pop_i,
  input logic       ready_res_o,
  input logic       done_res_o,
  input logic       scl_drive_low_o,
  input logic       sda_drive_low_o,
  input logic [7:0] read_byte_o
);

  // A tick taken while idle never also completes a command.
  a_ready_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> !(ready_res_o && done_res_o))
    else $error("ready and done both set on one result");

  // Hold a waiting result until it is popped.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(read_byte_o)
      && $stable(scl_drive_low_o) && $stable(sda_drive_low_o)))
    else $error("stalled result changed");

  // Both queues come out of reset drained.
  a_reset_drained: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty_o && !full_o))
    else $error("queues not empty after reset");

endmodule

bind i2c_master_bit_engine_core i2cm_checker u_i2cm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .full_o          (full_o),
  .empty_o         (empty_o),
  .pop_i           (pop_i),
  .ready_res_o     (ready_res_o),
  .done_res_o      (done_res_o),
  .scl_drive_low_o (scl_drive_low_o),
  .sda_drive_low_o (sda_drive_low_o),
  .read_byte_o     (read_byte_o)
);
